// ===== rtl/pcch_pkg.sv =====
// ----------------------------------------------------------------------------
// pcch_pkg: shared types and constants of the pixel color class histogram
// Holds the bin codes, the configuration register indexes, the field widths
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcch_pkg;

    // Pixel channel and result field widths.
    localparam int CHAN_W      = 8;
    localparam int BIN_W       = 4;
    localparam int RES_COUNT_W = 32;

    // Color classes, in the order the results are sent out.
    localparam int NUM_BINS = 9;
    localparam logic [BIN_W-1:0] BIN_RED     = 4'd0;
    localparam logic [BIN_W-1:0] BIN_YELLOW  = 4'd1;
    localparam logic [BIN_W-1:0] BIN_GREEN   = 4'd2;
    localparam logic [BIN_W-1:0] BIN_CYAN    = 4'd3;
    localparam logic [BIN_W-1:0] BIN_BLUE    = 4'd4;
    localparam logic [BIN_W-1:0] BIN_MAGENTA = 4'd5;
    localparam logic [BIN_W-1:0] BIN_WHITE   = 4'd6;
    localparam logic [BIN_W-1:0] BIN_BLACK   = 4'd7;
    localparam logic [BIN_W-1:0] BIN_GRAY    = 4'd8;
    localparam logic [BIN_W-1:0] BIN_LAST    = BIN_W'(NUM_BINS - 1);

    // Configuration register file.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_SUM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_SUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SAT   = 2'd2;

    localparam int SUM_W  = 9;
    localparam int PERM_W = 10;
    localparam logic [SUM_W-1:0]  DARK_SUM_RESET   = 9'd15;
    localparam logic [SUM_W-1:0]  BRIGHT_SUM_RESET = 9'd459;
    localparam logic [PERM_W-1:0] GRAY_SAT_RESET   = 10'd150;

    // Saturation is compared in thousandths.
    localparam logic [PERM_W-1:0] PERMILLE_SCALE = 10'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             pix_load;   // a pixel beat is accepted
        logic             emit_load;  // load the result register with bin emit_idx
        logic [BIN_W-1:0] emit_idx;
        logic             clear;      // zero all counters
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;  // a pixel is still on its way to the counters
    } t_dp_status;

endpackage

// ===== rtl/pcch_if.sv =====
// ----------------------------------------------------------------------------
// pcch_if: channel interfaces of the pixel color class histogram
// Pixel input stream, result output stream and configuration write channel,
// each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcch_pix_if;
    import pcch_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              end_of_image;

    modport source (output valid, red, green, blue, end_of_image, input ready);
    modport sink   (input valid, red, green, blue, end_of_image, output ready);
endinterface

interface pcch_res_if;
    import pcch_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [BIN_W-1:0]       bin_index;
    logic [RES_COUNT_W-1:0] bin_count;
    logic [RES_COUNT_W-1:0] pixel_total;
    logic                   last_bin;

    modport source (output valid, bin_index, bin_count, pixel_total, last_bin,
                    input ready);
    modport sink   (input valid, bin_index, bin_count, pixel_total, last_bin,
                    output ready);
endinterface

interface pcch_cfg_if;
    import pcch_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pcch_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcch_ctrl: controller of the pixel color class histogram
// Takes pixels, waits for the pipeline to drain after the last pixel of an
// image and then steps the nine result beats out through the result register.
// ----------------------------------------------------------------------------
module pcch_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_eoi,
    output logic                  o_pix_ready,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    output pcch_pkg::t_ctrl_cmd   o_cmd,
    input  pcch_pkg::t_dp_status  i_sts
);
    import pcch_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic [BIN_W-1:0] r_idx;
    logic             emit_load;

    assign o_pix_ready = (r_state == S_RUN);
    assign emit_load   = (r_state == S_EMIT) && (!r_out_valid || i_res_ready);

    assign o_cmd.pix_load  = i_pix_valid && o_pix_ready;
    assign o_cmd.emit_load = emit_load;
    assign o_cmd.emit_idx  = r_idx;
    assign o_cmd.clear     = emit_load && (r_idx == BIN_LAST);

    assign o_res_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (o_cmd.pix_load && i_pix_eoi) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_load) begin
                        if (r_idx == BIN_LAST) begin
                            r_idx   <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The counters must be settled before any of them is sent out.
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_sts.pipe_busy)
        else $error("result emission started with a pixel still in flight");

    // Counters are cleared only together with the last bin's load.
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (emit_load && (r_idx == BIN_LAST)))
        else $error("counter clear outside the last result load");

    // The last result load hands control back to pixel intake.
    a_back_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && (r_idx == BIN_LAST)) |=> (r_state == S_RUN))
        else $error("controller did not return to pixel intake");

    // An end-of-image pixel stops intake on the next cycle.
    a_eoi_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pix_load && i_pix_eoi) |=> !o_pix_ready)
        else $error("pixel intake continued after end of image");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= BIN_LAST)
        else $error("result index ran past the last bin");

endmodule

// ===== rtl/pcch_datapath.sv =====
// ----------------------------------------------------------------------------
// pcch_datapath: datapath of the pixel color class histogram
// Three-stage pixel classifier, saturating class and pixel counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module pcch_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcch_pkg::t_ctrl_cmd                    i_cmd,
    output pcch_pkg::t_dp_status                   o_sts,
    input  logic [pcch_pkg::CHAN_W-1:0]            i_red,
    input  logic [pcch_pkg::CHAN_W-1:0]            i_green,
    input  logic [pcch_pkg::CHAN_W-1:0]            i_blue,
    input  logic                                   i_cfg_we,
    input  logic [pcch_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcch_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [pcch_pkg::BIN_W-1:0]             o_bin_index,
    output logic [pcch_pkg::RES_COUNT_W-1:0]       o_bin_count,
    output logic [pcch_pkg::RES_COUNT_W-1:0]       o_pixel_total,
    output logic                                   o_last_bin
);
    import pcch_pkg::*;

    localparam int DIFF_W = CHAN_W;
    localparam int PROD_W = DIFF_W + PERM_W;
    localparam int NUM_W  = CHAN_W + 1;
    localparam int T_W    = CHAN_W + 3;
    localparam int SEC_W  = 3;

    // Configuration registers.
    logic [SUM_W-1:0]  r_dark_sum;
    logic [SUM_W-1:0]  r_bright_sum;
    logic [PERM_W-1:0] r_gray_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_sum   <= DARK_SUM_RESET;
            r_bright_sum <= BRIGHT_SUM_RESET;
            r_gray_sat   <= GRAY_SAT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DARK_SUM:   r_dark_sum   <= i_cfg_data[SUM_W-1:0];
                CFG_BRIGHT_SUM: r_bright_sum <= i_cfg_data[SUM_W-1:0];
                CFG_GRAY_SAT:   r_gray_sat   <= i_cfg_data[PERM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- Stage 1: registered pixel, channel extremes ----------
    logic              r_v1;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    logic [CHAN_W-1:0]       mx, mn, sum_gap, den, hue_a, hue_b;
    logic [DIFF_W-1:0]       diff;
    logic [SUM_W-1:0]        sum;
    logic signed [NUM_W-1:0] num;
    logic [SEC_W-1:0]        base;

    always_comb begin
        mx = r_red;
        if (r_green > mx) mx = r_green;
        if (r_blue > mx)  mx = r_blue;
        mn = r_red;
        if (r_green < mn) mn = r_green;
        if (r_blue < mn)  mn = r_blue;
        sum  = {1'b0, mx} + {1'b0, mn};
        diff = mx - mn;
        if (sum >= SUM_W'(255)) begin
            sum_gap = CHAN_W'(sum - SUM_W'(255));
        end else begin
            sum_gap = CHAN_W'(SUM_W'(255) - sum);
        end
        den = CHAN_W'(255) - sum_gap;
        // Red wins a tie for the largest channel, then green.
        if (r_red == mx) begin
            hue_a = r_green;
            hue_b = r_blue;
            base  = SEC_W'(BIN_RED);
        end else if (r_green == mx) begin
            hue_a = r_blue;
            hue_b = r_red;
            base  = SEC_W'(BIN_GREEN);
        end else begin
            hue_a = r_red;
            hue_b = r_green;
            base  = SEC_W'(BIN_BLUE);
        end
        num = $signed({1'b0, hue_a}) - $signed({1'b0, hue_b});
    end

    // ---------------- Stage 2: features ------------------------------------
    logic                    r_v2;
    logic                    r_s2_black, r_s2_white;
    logic [DIFF_W-1:0]       r_s2_diff;
    logic [CHAN_W-1:0]       r_s2_den;
    logic signed [NUM_W-1:0] r_s2_num;
    logic [SEC_W-1:0]        r_s2_base;

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s2_black <= (sum <= r_dark_sum);
            r_s2_white <= (sum > r_bright_sum);
            r_s2_diff  <= diff;
            r_s2_den   <= den;
            r_s2_num   <= num;
            r_s2_base  <= base;
        end
    end

    logic [PROD_W-1:0]     sat_lhs, sat_rhs;
    logic                  is_gray;
    logic signed [T_W-1:0] hue_t, two_diff;
    logic [SEC_W-1:0]      sector;
    logic [BIN_W-1:0]      bin;

    always_comb begin
        sat_lhs = PROD_W'(r_s2_diff) * PROD_W'(PERMILLE_SCALE);
        sat_rhs = PROD_W'(r_gray_sat) * PROD_W'(r_s2_den);
        is_gray = (sat_lhs < sat_rhs);

        // Sector offset: below when 2*num + diff < 0, above when it reaches 2*diff.
        hue_t    = (T_W'(r_s2_num) <<< 1) + $signed(T_W'(r_s2_diff));
        two_diff = $signed(T_W'({r_s2_diff, 1'b0}));
        if (hue_t < 0) begin
            sector = (r_s2_base == '0) ? SEC_W'(BIN_MAGENTA) : r_s2_base - 1'b1;
        end else if (hue_t >= two_diff) begin
            sector = r_s2_base + 1'b1;
        end else begin
            sector = r_s2_base;
        end

        priority if (r_s2_black) begin
            bin = BIN_BLACK;
        end else if (r_s2_white) begin
            bin = BIN_WHITE;
        end else if (r_s2_diff == '0) begin
            bin = (r_gray_sat != '0) ? BIN_GRAY : BIN_RED;
        end else if (is_gray) begin
            bin = BIN_GRAY;
        end else begin
            bin = BIN_W'(sector);
        end
    end

    // ---------------- Stage 3: class code, counters -------------------------
    logic             r_v3;
    logic [BIN_W-1:0] r_s3_bin;

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_s3_bin <= bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pix_load;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3;

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_BINS];
    logic [COUNT_WIDTH-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r_cnt[k] <= '0;
            end
            r_total <= '0;
        end else if (r_v3) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                if ((r_s3_bin == BIN_W'(k)) && (r_cnt[k] != '1)) begin
                    r_cnt[k] <= r_cnt[k] + 1'b1;
                end
            end
            if (r_total != '1) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // ---------------- Result register ----------------------------------------
    logic [COUNT_WIDTH-1:0] cnt_sel;
    logic [RES_COUNT_W-1:0] cnt_out, total_out;

    assign cnt_sel = r_cnt[i_cmd.emit_idx];

    // Counts wider than the result field clip to its maximum.
    if (COUNT_WIDTH > RES_COUNT_W) begin : g_clip
        assign cnt_out   = (|cnt_sel[COUNT_WIDTH-1:RES_COUNT_W]) ? '1
                                                                  : cnt_sel[RES_COUNT_W-1:0];
        assign total_out = (|r_total[COUNT_WIDTH-1:RES_COUNT_W]) ? '1
                                                                  : r_total[RES_COUNT_W-1:0];
    end else begin : g_extend
        assign cnt_out   = RES_COUNT_W'(cnt_sel);
        assign total_out = RES_COUNT_W'(r_total);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_bin_index   <= i_cmd.emit_idx;
            o_bin_count   <= cnt_out;
            o_pixel_total <= total_out;
            o_last_bin    <= (i_cmd.emit_idx == BIN_LAST);
        end
    end

endmodule

// ===== rtl/pixel_color_class_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_color_class_histogram_unit: RGB pixel color class histogram
// Sorts pixels into nine color classes, counts them, and reports the counts
// and the pixel total at the end of every image.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel per clock on the pixel channel and sorts it
// into black, white, gray or one of six hue sectors (red, yellow, green, cyan,
// blue, magenta), using exact integer tests on the largest and smallest
// channel. A three-stage classifier pipeline feeds nine saturating class
// counters and a saturating pixel total. When a pixel beat carries
// end_of_image, that pixel is counted, intake pauses, and once the pipeline
// has drained the block sends nine result beats, one per class in bin order
// 0 to 8, each with the class count and the image's pixel total, last_bin set
// on the ninth. The counters are cleared as the ninth beat is loaded. Pixel
// intake resumes while that final beat still sits in the result register.
// Throughput is one pixel per clock within an image; after each end of image
// intake stays paused while the classifier drains and the nine results are
// loaded, and for as long as the result side holds ready low. Configuration
// writes are always taken and should be issued only while the block is idle
// between images.
module pixel_color_class_histogram_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pcch_pix_if.sink   i_pix,
    pcch_res_if.source o_res,
    pcch_cfg_if.sink   i_cfg
);
    import pcch_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    // Register writes never stall.
    assign i_cfg.ready = 1'b1;

    // The controller owns the handshakes and the emission sequence.
    pcch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .i_pix_eoi   (i_pix.end_of_image),
        .o_pix_ready (i_pix.ready),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath classifies, counts and holds the result payload.
    pcch_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_red         (i_pix.red),
        .i_green       (i_pix.green),
        .i_blue        (i_pix.blue),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_bin_index   (o_res.bin_index),
        .o_bin_count   (o_res.bin_count),
        .o_pixel_total (o_res.pixel_total),
        .o_last_bin    (o_res.last_bin)
    );

endmodule
